FILE: hdl/fdd_pkg.sv
// ----------------------------------------------------------------------------
// fdd_pkg - shared types and codes for the directory entry decoder
// Word layouts for the entry and result channels, configuration register
// indexes and entry kind codes.
// ----------------------------------------------------------------------------
package fdd_pkg;

	// Entry kind codes
	localparam logic [2:0] KIND_END       = 3'd0;
	localparam logic [2:0] KIND_DELETED   = 3'd1;
	localparam logic [2:0] KIND_LONG_NAME = 3'd2;
	localparam logic [2:0] KIND_VOLUME    = 3'd3;
	localparam logic [2:0] KIND_HIDDEN    = 3'd4;
	localparam logic [2:0] KIND_FILE      = 3'd5;
	localparam logic [2:0] KIND_DIRECTORY = 3'd6;

	// Byte and field constants of a short directory entry
	localparam logic [7:0]  MARK_DELETED   = 8'hE5;
	localparam logic [7:0]  ATTR_LONG_NAME = 8'h0F;
	localparam logic [7:0]  ATTR_VOLUME    = 8'h08;
	localparam int          ATTR_HIDDEN_BIT = 1;
	localparam logic [11:0] YEAR_BASE      = 12'd1980;
	localparam logic [7:0]  LFN_CHARS      = 8'd13;
	localparam logic [7:0]  LFN_MAX        = 8'd255;
	localparam logic [31:0] ROOT_CLUSTER_OFS = 32'd2;

	// Configuration register indexes
	localparam int          CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_DATA_SECTOR   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SECTORS_PER_CLUSTER = 2'd1;

	typedef struct packed {
		logic        new_directory;
		logic [63:0] entry_bytes_lo;
		logic [63:0] entry_bytes_mid;
		logic [63:0] entry_bytes_upper;
		logic [63:0] entry_bytes_top;
	} entry_word_t;

	typedef struct packed {
		logic [2:0]  entry_kind;
		logic [31:0] file_size;
		logic [31:0] cluster_sector;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [3:0]  hour_twelve;
		logic [5:0]  minute;
		logic        is_pm;
		logic [31:0] listed_count;
		logic [31:0] listed_bytes;
		logic [7:0]  long_name_length;
	} result_word_t;

	typedef struct packed {
		logic [31:0] first_data_sector;
		logic [7:0]  sectors_per_cluster;
	} cfg_t;

	// Running per-directory state
	typedef struct packed {
		logic [31:0] count_listed;
		logic [31:0] bytes_listed;
		logic [7:0]  name_char_count;
		logic        end_seen;
	} dir_state_t;

endpackage

FILE: hdl/fdd_cfg.sv
// ----------------------------------------------------------------------------
// fdd_cfg - configuration register file
// Holds the data region start sector and the cluster size.
// ----------------------------------------------------------------------------
module fdd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [fdd_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [31:0]                     wr_data,
	output fdd_pkg::cfg_t                   cfg
);

	logic [31:0] first_data_sector_q;
	logic [7:0]  sectors_per_cluster_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_data_sector_q   <= 32'd0;
			sectors_per_cluster_q <= 8'd1;
		end else if (wr_en) begin
			case (wr_index)
				fdd_pkg::CFG_FIRST_DATA_SECTOR:   first_data_sector_q   <= wr_data;
				fdd_pkg::CFG_SECTORS_PER_CLUSTER: sectors_per_cluster_q <= wr_data[7:0];
				default: ;  // drop writes to unmapped indexes
			endcase
		end
	end

	assign cfg.first_data_sector   = first_data_sector_q;
	assign cfg.sectors_per_cluster = sectors_per_cluster_q;

endmodule

FILE: hdl/fdd_decode.sv
// ----------------------------------------------------------------------------
// fdd_decode - single-pass entry classification and field decode
// Classifies one entry, decodes its fields and computes the next running
// directory state.
// ----------------------------------------------------------------------------
module fdd_decode (
	input  fdd_pkg::entry_word_t  entry,
	input  fdd_pkg::cfg_t         cfg,
	input  fdd_pkg::dir_state_t   state_cur,
	output fdd_pkg::result_word_t result,
	output fdd_pkg::dir_state_t   state_nxt
);

	fdd_pkg::dir_state_t st;
	logic [7:0]  first_byte;
	logic [7:0]  attr;
	logic [15:0] tm;
	logic [15:0] dt;
	logic [31:0] clus;
	logic [31:0] size;
	logic [4:0]  raw_hour;
	logic [4:0]  hour_mod;
	logic [39:0] prod;
	logic [8:0]  lfn_sum;
	logic [7:0]  lfn_sat;

	always_comb begin
		first_byte = entry.entry_bytes_lo[7:0];
		attr       = entry.entry_bytes_mid[31:24];
		tm         = entry.entry_bytes_upper[63:48];
		dt         = entry.entry_bytes_top[15:0];
		clus       = {entry.entry_bytes_upper[47:32], entry.entry_bytes_top[31:16]};
		size       = entry.entry_bytes_top[63:32];
		raw_hour   = tm[15:11];
		prod       = (clus - fdd_pkg::ROOT_CLUSTER_OFS) * {32'd0, cfg.sectors_per_cluster};
		lfn_sum    = {1'b0, state_cur.name_char_count} + {1'b0, fdd_pkg::LFN_CHARS};

		// Clear the directory state first when a new directory starts
		st = state_cur;
		if (entry.new_directory) begin
			st = '0;
		end
		lfn_sum = {1'b0, st.name_char_count} + {1'b0, fdd_pkg::LFN_CHARS};
		lfn_sat = lfn_sum[8] ? fdd_pkg::LFN_MAX : lfn_sum[7:0];

		if (raw_hour < 5'd12) begin
			hour_mod = raw_hour;
		end else if (raw_hour < 5'd24) begin
			hour_mod = raw_hour - 5'd12;
		end else begin
			hour_mod = raw_hour - 5'd24;
		end

		result                  = '0;
		result.long_name_length = st.name_char_count;
		state_nxt               = st;

		if (st.end_seen) begin
			result.entry_kind = fdd_pkg::KIND_END;
		end else if (first_byte == 8'h00) begin
			result.entry_kind  = fdd_pkg::KIND_END;
			state_nxt.end_seen = 1'b1;
		end else if (first_byte == fdd_pkg::MARK_DELETED) begin
			result.entry_kind = fdd_pkg::KIND_DELETED;
		end else if (attr == fdd_pkg::ATTR_LONG_NAME) begin
			result.entry_kind         = fdd_pkg::KIND_LONG_NAME;
			state_nxt.name_char_count = lfn_sat;
			result.long_name_length   = lfn_sat;
		end else if (attr == fdd_pkg::ATTR_VOLUME) begin
			result.entry_kind = fdd_pkg::KIND_VOLUME;
		end else if (attr[fdd_pkg::ATTR_HIDDEN_BIT]) begin
			result.entry_kind         = fdd_pkg::KIND_HIDDEN;
			state_nxt.name_char_count = 8'd0;
		end else begin
			result.entry_kind  = (size != 32'd0) ? fdd_pkg::KIND_FILE
			                                     : fdd_pkg::KIND_DIRECTORY;
			result.file_size   = size;
			result.cluster_sector = (clus == 32'd0) ? cfg.first_data_sector
			                        : cfg.first_data_sector + prod[31:0];
			result.year        = fdd_pkg::YEAR_BASE + {5'd0, dt[15:9]};
			result.month       = dt[8:5];
			result.day         = dt[4:0];
			result.minute      = tm[10:5];
			result.is_pm       = (raw_hour >= 5'd12);
			result.hour_twelve = (hour_mod == 5'd0) ? 4'd12 : hour_mod[3:0];
			if (st.count_listed != 32'hFFFF_FFFF) begin
				state_nxt.count_listed = st.count_listed + 32'd1;
			end
			state_nxt.bytes_listed    = st.bytes_listed + size;
			state_nxt.name_char_count = 8'd0;
		end

		result.listed_count = state_nxt.count_listed;
		result.listed_bytes = state_nxt.bytes_listed;
	end

endmodule

FILE: hdl/fat32_dir_entry_decoder.sv
// ----------------------------------------------------------------------------
// fat32_dir_entry_decoder - FAT32 short/long directory entry decoder
// Classifies 32-byte directory entries and keeps per-directory totals.
// ----------------------------------------------------------------------------
// Feed one 32-byte directory entry per word on the input channel, bytes in
// little-endian order across the four 64-bit fields. Each entry yields exactly
// one result word: its kind (end, deleted, long-name part, volume, hidden,
// file or directory), and for files and directories the size, the start
// sector of the first cluster (the root start when the cluster is zero), the
// date, and the time on a 12-hour clock. Every result also carries the
// running listed count, the listed byte total and the long-name character
// count. Once an end marker is seen, every entry reports end and leaves the
// totals alone until a word arrives with new_directory set, which clears the
// totals before that entry is decoded. Throughput is one entry per cycle while
// the result side is not stalled: an entry is held in the input register
// while it is decoded, then moves into the result register, which raises
// out_valid; the word is taken on an edge with out_stall low. The
// input register frees up whenever the result register is
// empty or being taken, so input is only stalled while a result is stalled
// and a second entry is already waiting. Configuration writes are always
// ready (cfg_ready is tied high) and should be issued only while idle.
// ----------------------------------------------------------------------------
module fat32_dir_entry_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	// entry channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  fdd_pkg::entry_word_t            in_word,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output fdd_pkg::result_word_t           out_word,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fdd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data
);

	fdd_pkg::cfg_t         cfg;
	fdd_pkg::entry_word_t  entry_s1;
	logic                  valid_s1;
	fdd_pkg::dir_state_t   state_q;
	fdd_pkg::dir_state_t   state_nxt;
	fdd_pkg::result_word_t result;
	fdd_pkg::result_word_t out_word_q;
	logic                  out_valid_q;
	logic                  advance;
	logic                  in_take;

	assign cfg_ready = 1'b1;

	fdd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Move the held entry to the result register when that register is free
	// or its word is leaving this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			entry_s1 <= in_word;
		end
	end

	fdd_decode u_decode (
		.entry     (entry_s1),
		.cfg       (cfg),
		.state_cur (state_q),
		.result    (result),
		.state_nxt (state_nxt)
	);

	// Running directory state: advance only when an entry is retired
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`ifndef SYNTHESIS
	// Input is only stalled while an entry is held
	a_stall_needs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	// A retired end marker latches the end state
	a_end_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result.entry_kind == fdd_pkg::KIND_END) |=> state_q.end_seen)
		else $error("end marker did not latch");

	// Only files and directories carry a size or a sector
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_word_q.entry_kind != fdd_pkg::KIND_FILE
		 && out_word_q.entry_kind != fdd_pkg::KIND_DIRECTORY)
		|-> (out_word_q.file_size == 32'd0 && out_word_q.cluster_sector == 32'd0))
		else $error("size or sector set on a non-listed entry");

	// While the end is latched, retiring an entry leaves the totals alone
	a_end_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.end_seen && !entry_s1.new_directory)
		|=> $stable(state_q))
		else $error("state changed after the end marker");
`endif

endmodule

FILE: tb/fdd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdd_checker - result predictor and scoreboard for the directory decoder
// Watches the entry, result and configuration channels, predicts each result
// word from the accepted entry and compares it field by field.
// ----------------------------------------------------------------------------
module fdd_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  fdd_pkg::entry_word_t            in_word,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  fdd_pkg::result_word_t           out_word,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [fdd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data,
	output int                              mismatches,
	output int                              pending
);

	logic [31:0]           root_sector;
	logic [7:0]            cluster_sectors;
	fdd_pkg::dir_state_t   dir_totals;
	fdd_pkg::result_word_t expected_results[$];
	int                    errors;

	function automatic fdd_pkg::result_word_t decode_entry(input fdd_pkg::entry_word_t e);
		fdd_pkg::result_word_t r;
		logic [7:0]   lead;
		logic [7:0]   attr;
		logic [15:0]  tm;
		logic [15:0]  dt;
		logic [31:0]  clus;
		logic [4:0]   raw_hour;
		logic [4:0]   hour_mod;
		r = '0;
		if (e.new_directory) begin
			dir_totals = '0;
		end
		r.long_name_length = dir_totals.name_char_count;
		lead = e.entry_bytes_lo[7:0];
		attr = e.entry_bytes_mid[31:24];
		if (dir_totals.end_seen) begin
			r.entry_kind = fdd_pkg::KIND_END;
		end else if (lead == 8'h00) begin
			r.entry_kind = fdd_pkg::KIND_END;
			dir_totals.end_seen = 1'b1;
		end else if (lead == fdd_pkg::MARK_DELETED) begin
			r.entry_kind = fdd_pkg::KIND_DELETED;
		end else if (attr == fdd_pkg::ATTR_LONG_NAME) begin
			r.entry_kind = fdd_pkg::KIND_LONG_NAME;
			if (dir_totals.name_char_count > fdd_pkg::LFN_MAX - fdd_pkg::LFN_CHARS)
				dir_totals.name_char_count = fdd_pkg::LFN_MAX;
			else
				dir_totals.name_char_count = dir_totals.name_char_count
					+ fdd_pkg::LFN_CHARS;
			r.long_name_length = dir_totals.name_char_count;
		end else if (attr == fdd_pkg::ATTR_VOLUME) begin
			r.entry_kind = fdd_pkg::KIND_VOLUME;
		end else if (attr[fdd_pkg::ATTR_HIDDEN_BIT]) begin
			r.entry_kind = fdd_pkg::KIND_HIDDEN;
			dir_totals.name_char_count = '0;
		end else begin
			tm = e.entry_bytes_upper[63:48];
			dt = e.entry_bytes_top[15:0];
			clus = {e.entry_bytes_upper[47:32], e.entry_bytes_top[31:16]};
			r.file_size = e.entry_bytes_top[63:32];
			r.entry_kind = (r.file_size != 32'd0) ? fdd_pkg::KIND_FILE
			                                      : fdd_pkg::KIND_DIRECTORY;
			// cluster zero points at the root, everything else wraps at 32 bits
			if (clus == 32'd0)
				r.cluster_sector = root_sector;
			else
				r.cluster_sector = root_sector
					+ (clus - fdd_pkg::ROOT_CLUSTER_OFS) * {24'd0, cluster_sectors};
			r.year = fdd_pkg::YEAR_BASE + {5'd0, dt[15:9]};
			r.month = dt[8:5];
			r.day = dt[4:0];
			raw_hour = tm[15:11];
			r.minute = tm[10:5];
			r.is_pm = (raw_hour >= 5'd12);
			hour_mod = raw_hour % 5'd12;
			r.hour_twelve = (hour_mod == 5'd0) ? 4'd12 : hour_mod[3:0];
			if (dir_totals.count_listed != 32'hFFFF_FFFF)
				dir_totals.count_listed = dir_totals.count_listed + 32'd1;
			dir_totals.bytes_listed = dir_totals.bytes_listed + r.file_size;
			dir_totals.name_char_count = '0;
		end
		r.listed_count = dir_totals.count_listed;
		r.listed_bytes = dir_totals.bytes_listed;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		fdd_pkg::result_word_t want;
		if (!arst_n) begin
			root_sector = '0;
			cluster_sectors = 8'd1;
			dir_totals = '0;
			expected_results.delete();
			errors = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fdd_pkg::CFG_FIRST_DATA_SECTOR: root_sector = cfg_data;
					fdd_pkg::CFG_SECTORS_PER_CLUSTER: cluster_sectors = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_results.push_back(decode_entry(in_word));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result word taken with no entry outstanding");
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("entry_kind", 32'(want.entry_kind),
						32'(out_word.entry_kind));
					check_field("file_size", want.file_size, out_word.file_size);
					check_field("cluster_sector", want.cluster_sector,
						out_word.cluster_sector);
					check_field("year", 32'(want.year), 32'(out_word.year));
					check_field("month", 32'(want.month), 32'(out_word.month));
					check_field("day", 32'(want.day), 32'(out_word.day));
					check_field("hour_twelve", 32'(want.hour_twelve),
						32'(out_word.hour_twelve));
					check_field("minute", 32'(want.minute), 32'(out_word.minute));
					check_field("is_pm", 32'(want.is_pm), 32'(out_word.is_pm));
					check_field("listed_count", want.listed_count,
						out_word.listed_count);
					check_field("listed_bytes", want.listed_bytes,
						out_word.listed_bytes);
					check_field("long_name_length", 32'(want.long_name_length),
						32'(out_word.long_name_length));
				end
			end
			mismatches <= errors;
			pending <= expected_results.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - directory entry decoder stimulus and verdict
// Drives directed and random directory entries through the decoder under
// several cluster geometries, with random idling on both channels, a long
// result hold-off and pauses for configuration. Checking is done by
// fdd_checker alongside the block.
// ----------------------------------------------------------------------------
module testbench;

	localparam int ENTRY_TARGET = 900;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 8;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	fdd_pkg::entry_word_t            in_word;
	logic                            out_valid;
	logic                            out_stall;
	fdd_pkg::result_word_t           out_word;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [fdd_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [31:0]                     cfg_data;

	int mismatches;
	int pending;
	int entries_sent;
	int settings_used;
	int cycle_count;

	// idling switches per phase, and a one-shot request for the long hold-off
	bit tx_idle_on;
	bit rx_idle_on;
	bit long_hold_req;
	// mirror of the end latch, only used to decide when to open a new directory
	bit end_latched;

	fat32_dir_entry_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fdd_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Give up after a generous number of cycles.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// Result side: stall a random number of cycles before each word, or hold
	// off for a long stretch when asked so the decoder backs up into its input.
	initial begin : result_sink
		int hold;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end else begin
				hold = rx_idle_on ? $urandom_range(0, 19) : 0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Assemble a 32-byte entry; bytes without a decoded meaning stay random.
	function automatic fdd_pkg::entry_word_t build_entry(input logic fresh,
		input logic [7:0] lead, input logic [7:0] attr, input logic [31:0] size,
		input logic [31:0] clus, input logic [15:0] dt, input logic [15:0] tm);
		logic [255:0]         raw;
		fdd_pkg::entry_word_t e;
		for (int i = 0; i < 8; i++)
			raw[32*i +: 32] = $urandom();
		raw[7:0]     = lead;
		raw[95:88]   = attr;
		raw[175:160] = clus[31:16];
		raw[191:176] = tm;
		raw[207:192] = dt;
		raw[223:208] = clus[15:0];
		raw[255:224] = size;
		e.new_directory     = fresh;
		e.entry_bytes_lo    = raw[63:0];
		e.entry_bytes_mid   = raw[127:64];
		e.entry_bytes_upper = raw[191:128];
		e.entry_bytes_top   = raw[255:192];
		return e;
	endfunction

	// Open a new directory now and then, and often once the end has latched.
	function automatic logic next_fresh();
		if (end_latched)
			return ($urandom_range(0, 1) == 0);
		return ($urandom_range(0, 29) == 0);
	endfunction

	// First byte that is neither an end marker nor a deleted mark.
	function automatic logic [7:0] plain_lead();
		logic [7:0] lead;
		lead = 8'($urandom_range(1, 255));
		if (lead == fdd_pkg::MARK_DELETED)
			lead = 8'h41;
		return lead;
	endfunction

	// Attribute of a visible short entry: hidden bit clear, not a volume label.
	function automatic logic [7:0] visible_attr();
		logic [7:0] attr;
		attr = 8'($urandom_range(0, 255));
		attr[fdd_pkg::ATTR_HIDDEN_BIT] = 1'b0;
		if (attr == fdd_pkg::ATTR_VOLUME)
			attr = 8'h20;
		return attr;
	endfunction

	function automatic logic [7:0] hidden_attr();
		logic [7:0] attr;
		attr = 8'($urandom_range(0, 255));
		attr[fdd_pkg::ATTR_HIDDEN_BIT] = 1'b1;
		if (attr == fdd_pkg::ATTR_LONG_NAME)
			attr = 8'h06;
		return attr;
	endfunction

	// Zero sizes make directories; all-ones sizes push the byte total to wrap.
	function automatic logic [31:0] random_size();
		case ($urandom_range(0, 9))
			0, 1: return 32'd0;
			2: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] random_cluster();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'd2;
			default: return $urandom();
		endcase
	endfunction

	// Offer one word after a random gap and hold it until it is taken.
	task automatic send_entry(input fdd_pkg::entry_word_t e);
		int gap;
		bit ignored;
		gap = tx_idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// entries behind a latched end change nothing, so don't count them
		ignored = end_latched && !e.new_directory;
		if (e.new_directory)
			end_latched = 1'b0;
		if (!end_latched && e.entry_bytes_lo[7:0] == 8'h00)
			end_latched = 1'b1;
		if (!ignored)
			entries_sent++;
	endtask

	// Drop valid and hold until every outstanding result word has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fdd_pkg::CFG_INDEX_W-1:0] idx,
		input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Reprogram the geometry only once the decoder has gone idle.
	task automatic apply_setting(input logic [31:0] root, input logic [31:0] spc_data);
		drain_results();
		write_reg(fdd_pkg::CFG_FIRST_DATA_SECTOR, root);
		write_reg(fdd_pkg::CFG_SECTORS_PER_CLUSTER, spc_data);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// A well-formed run: some long-name parts, then the short entry they name.
	task automatic send_group();
		int parts;
		if ($urandom_range(0, 4) == 0)
			parts = $urandom_range(5, 22);
		else
			parts = $urandom_range(0, 4);
		repeat (parts)
			send_entry(build_entry(next_fresh(), plain_lead(), fdd_pkg::ATTR_LONG_NAME,
				$urandom(), $urandom(), 16'($urandom()), 16'($urandom())));
		if ($urandom_range(0, 5) == 0)
			send_entry(build_entry(next_fresh(), plain_lead(), hidden_attr(),
				$urandom(), $urandom(), 16'($urandom()), 16'($urandom())));
		else
			send_entry(build_entry(next_fresh(), plain_lead(), visible_attr(),
				random_size(), random_cluster(), 16'($urandom()), 16'($urandom())));
	endtask

	// Noise: end markers, deleted slots, volume labels and raw random bytes.
	task automatic send_noise();
		case ($urandom_range(0, 5))
			0: send_entry(build_entry(next_fresh(), 8'h00, 8'($urandom()),
				$urandom(), $urandom(), 16'($urandom()), 16'($urandom())));
			1: send_entry(build_entry(next_fresh(), fdd_pkg::MARK_DELETED,
				8'($urandom()), $urandom(), $urandom(), 16'($urandom()),
				16'($urandom())));
			2: send_entry(build_entry(next_fresh(), plain_lead(), fdd_pkg::ATTR_VOLUME,
				$urandom(), $urandom(), 16'($urandom()), 16'($urandom())));
			default: send_entry(build_entry(next_fresh(), 8'($urandom()),
				8'($urandom()), $urandom(), $urandom(), 16'($urandom()),
				16'($urandom())));
		endcase
	endtask

	task automatic run_random(input int goal);
		int stop_at;
		stop_at = entries_sent + goal;
		while (entries_sent < stop_at) begin
			if ($urandom_range(0, 9) < 7)
				send_group();
			else
				send_noise();
		end
	endtask

	// Directed entries at reset geometry: field extremes, every kind, the
	// kind priorities, long-name counting, end latching and a new directory.
	task automatic run_directed();
		// all-ones size, cluster, date and time: year 2107, hour 31 -> 7 PM
		send_entry(build_entry(1'b1, 8'h41, 8'h20, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 16'hFFFF));
		// empty directory at the root, midnight shows as 12 AM
		send_entry(build_entry(1'b0, 8'h42, 8'h00, 32'd0, 32'd0, 16'h0000, 16'h0000));
		// cluster 1 wraps below the data region, noon is 12 PM
		send_entry(build_entry(1'b0, 8'h43, 8'h01, 32'd1, 32'd1, 16'h5A21,
			16'd12 << 11));
		// directory attribute with a nonzero size still counts as a file
		send_entry(build_entry(1'b0, 8'hFF, 8'h10, 32'h8000_0000, 32'd2, 16'h1234,
			(16'd11 << 11) | (16'd59 << 5)));
		// deleted mark wins over a long-name attribute
		send_entry(build_entry(1'b0, fdd_pkg::MARK_DELETED, fdd_pkg::ATTR_LONG_NAME,
			32'd5, 32'd7, 16'h0, 16'h0));
		repeat (3)
			send_entry(build_entry(1'b0, 8'h01, fdd_pkg::ATTR_LONG_NAME, $urandom(),
				$urandom(), 16'($urandom()), 16'($urandom())));
		// volume label reports the count so far, then the file takes and clears it
		send_entry(build_entry(1'b0, 8'h56, fdd_pkg::ATTR_VOLUME, 32'd9, 32'd9,
			16'h0, 16'h0));
		send_entry(build_entry(1'b0, 8'h46, 8'h20, 32'd100, 32'd3, 16'h4C8F, 16'h7BE0));
		send_entry(build_entry(1'b0, 8'h02, fdd_pkg::ATTR_LONG_NAME, 32'd0, 32'd0,
			16'h0, 16'h0));
		send_entry(build_entry(1'b0, 8'h48, 8'h02, 32'd77, 32'd4, 16'h0, 16'h0));
		// all attribute bits set reads as hidden
		send_entry(build_entry(1'b0, 8'h48, 8'hFF, 32'd77, 32'd4, 16'h0, 16'h0));
		send_entry(build_entry(1'b0, 8'h49, 8'h0D, 32'd3000, 32'd10, 16'hA5A5,
			16'h5A5A));
		// end marker latches; the valid file behind it still reports end
		send_entry(build_entry(1'b0, 8'h00, 8'h20, 32'd1, 32'd1, 16'h0, 16'h0));
		send_entry(build_entry(1'b0, 8'h4A, 8'h20, 32'd50, 32'd6, 16'h0, 16'h0));
		// a new directory clears totals first, then an end marker latches again
		send_entry(build_entry(1'b1, 8'h4B, 8'h20, 32'd60, 32'd6, 16'h0, 16'h0));
		send_entry(build_entry(1'b1, 8'h00, 8'h20, 32'd70, 32'd6, 16'h0, 16'h0));
		send_entry(build_entry(1'b1, 8'h4C, 8'h00, 32'd0, 32'h0FFF_FFFF, 16'hFFFF,
			16'h0000));
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		long_hold_req = 1'b0;
		end_latched = 1'b0;
		entries_sent = 0;
		settings_used = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// top of the sector range with the largest legal cluster
		apply_setting(32'hFFFF_FFF0, 32'd128);
		run_random(150);

		// back-to-back words, no idling on either side
		apply_setting($urandom(), $urandom_range(1, 128));
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_random(150);

		// hold results off for a long stretch while entries keep coming
		drain_results();
		long_hold_req = 1'b1;
		rx_idle_on = 1'b1;
		run_random(40);

		// zero sectors per cluster, only the sender idles
		apply_setting(32'd0, 32'hFFFF_FF00);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b0;
		run_random(120);

		// all-ones geometry, upper data bits ignored, only the receiver idles
		apply_setting(32'hFFFF_FFFF, 32'hA5A5_A5FF);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		run_random(120);

		apply_setting($urandom(), 32'h1234_5601);
		tx_idle_on = 1'b1;
		run_random(150);

		// typical card geometry for the rest
		apply_setting(32'd8192, 32'd8);
		if (entries_sent < ENTRY_TARGET)
			run_random(ENTRY_TARGET - entries_sent);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Decoded %0d live directory entries over %0d cluster geometries,",
			entries_sent, settings_used);
		$display("with random idling on both sides and one long result hold-off");
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: fat32_dir_entry_decoder.f
hdl/fdd_pkg.sv
hdl/fdd_cfg.sv
hdl/fdd_decode.sv
hdl/fat32_dir_entry_decoder.sv
tb/fdd_checker.sv
tb/testbench.sv
